// File: hdl/fmcr_pkg.sv
// fmcr_pkg: shared types, reset values and codes for the framed motor command receiver
// no dependencies; used by every module of the block
`default_nettype none

package fmcr_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0] START_RESET  = 8'h01;
  localparam logic [7:0] STOP_RESET   = 8'hBB;
  localparam logic [7:0] MAXLEN_RESET = 8'd251;
  localparam logic [7:0] SCALE_RESET  = 8'd10;

  localparam logic [7:0] REG_START_MARKER = 8'd0;
  localparam logic [7:0] REG_STOP_MARKER  = 8'd1;
  localparam logic [7:0] REG_MAX_LENGTH   = 8'd2;
  localparam logic [7:0] REG_SPEED_SCALE  = 8'd3;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_ADDR_ERR  = 3'd1;
  localparam logic [2:0] STATUS_MODE_ERR  = 3'd2;
  localparam logic [2:0] STATUS_LEN_ERR   = 3'd3;
  localparam logic [2:0] STATUS_TOO_SHORT = 3'd4;

  localparam logic [7:0] ADDR_MOTOR_ONE = 8'h01;
  localparam logic [7:0] ADDR_MOTOR_TWO = 8'h02;
  localparam logic [7:0] DIR_ONE        = 8'h01;
  localparam logic [7:0] DIR_TWO        = 8'h02;
  localparam logic [7:0] MODE_THREE     = 8'h03;
  localparam logic [7:0] MODE_FOUR      = 8'h04;
  localparam logic [7:0] LEN_MIN        = 8'h03;
  localparam logic [7:0] LEN_FOUR       = 8'h04;
  localparam logic [7:0] LEN_CHECKED    = 8'h05;
  localparam logic [7:0] LEN_SIX        = 8'h06;
  localparam logic [7:0] NO_ADDRESS     = 8'hFF;

  localparam logic [1:0] CH_ONE   = 2'd0;
  localparam logic [1:0] CH_TWO   = 2'd1;
  localparam logic [1:0] CH_THREE = 2'd2;
  localparam logic [1:0] CH_FOUR  = 2'd3;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] stop_marker;
    logic [7:0] max_length;
    logic [7:0] speed_scale;
  } cfg_t;

  // one classified byte handed from front to back
  typedef struct packed {
    logic       done;
    logic [2:0] status;
    logic [7:0] addr;
    logic       motor;
    logic [7:0] motor_addr;
    logic [7:0] direction;
    logic [7:0] speed;
  } cmd_t;

endpackage

`default_nettype wire

// File: hdl/fmcr_if.sv
// fmcr_if: valid/ready channel interfaces for received bytes, results and register writes
// depends on nothing but the field widths of the block
`default_nettype none

interface fmcr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface fmcr_result_if;
  logic        valid;
  logic        ready;
  logic        frame_done;
  logic [2:0]  status;
  logic [7:0]  reply_address;
  logic        motor_update;
  logic [3:0]  channel_enable;
  logic [15:0] compare_one;
  logic [15:0] compare_two;
  logic [15:0] compare_three;
  logic [15:0] compare_four;
  modport source (output valid, output frame_done, output status, output reply_address,
                  output motor_update, output channel_enable, output compare_one,
                  output compare_two, output compare_three, output compare_four,
                  input ready);
  modport sink (input valid, input frame_done, input status, input reply_address,
                input motor_update, input channel_enable, input compare_one,
                input compare_two, input compare_three, input compare_four,
                output ready);
endinterface

interface fmcr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// File: hdl/framed_motor_command_receiver_core.sv
// framed_motor_command_receiver_core: top level, register file, parser, queue and motor back end
// depends on fmcr_pkg, fmcr_if, fmcr_front, fmcr_queue and fmcr_back
`default_nettype none

// Takes one received byte per beat on rx_byte and returns exactly one result beat per byte on
// report: a frame report on the second stop marker, a motor update on the third payload byte,
// and always the current channel enables and compare values. With report.ready held high the
// block sustains one byte per clock; the result of a byte is registered in the queue and then
// in the output register of the back end. The queue between the parser and the back end
// holds QUEUE_DEPTH commands, so rx_byte.ready falls only once one result beat is held on
// report and QUEUE_DEPTH more wait behind it in the queue.
// Registers on cfg (start marker, stop marker, max length, speed scale) are always ready and
// should be written while no byte is in flight; writes to other indexes are ignored.
module framed_motor_command_receiver_core #(
  parameter int QUEUE_DEPTH = fmcr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire           clk,
  input  wire           rst,
  fmcr_rx_if.sink       rx_byte,
  fmcr_result_if.source report,
  fmcr_cfg_if.sink      cfg
);
  import fmcr_pkg::*;

  cfg_t cfg_regs;
  logic push;
  logic push_ready;
  cmd_t push_cmd;
  logic pop;
  logic pop_valid;
  cmd_t pop_cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.start_marker <= START_RESET;
      cfg_regs.stop_marker  <= STOP_RESET;
      cfg_regs.max_length   <= MAXLEN_RESET;
      cfg_regs.speed_scale  <= SCALE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_START_MARKER: cfg_regs.start_marker <= cfg.wdata;
        REG_STOP_MARKER:  cfg_regs.stop_marker  <= cfg.wdata;
        REG_MAX_LENGTH:   cfg_regs.max_length   <= cfg.wdata;
        REG_SPEED_SCALE:  cfg_regs.speed_scale  <= cfg.wdata;
        default: ;
      endcase
    end
  end

  fmcr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_regs),
    .rx_byte    (rx_byte),
    .push_ready (push_ready),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  fmcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd)
  );

  fmcr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .speed_scale (cfg_regs.speed_scale),
    .pop_valid   (pop_valid),
    .pop_cmd     (pop_cmd),
    .pop         (pop),
    .report      (report)
  );

endmodule

`default_nettype wire

// File: hdl/fmcr_front.sv
// fmcr_front: frame parser, tracks markers, length and payload, classifies each byte
// depends on fmcr_pkg and fmcr_rx_if; pushes one command per beat into the queue
`default_nettype none

module fmcr_front (
  input  wire                  clk,
  input  wire                  rst,
  input  fmcr_pkg::cfg_t       cfg,
  fmcr_rx_if.sink              rx_byte,
  input  wire                  push_ready,
  output logic                 push,
  output fmcr_pkg::cmd_t       push_cmd
);
  import fmcr_pkg::*;

  typedef enum logic [2:0] {
    ST_HUNT   = 3'd0,
    ST_START2 = 3'd1,
    ST_LENGTH = 3'd2,
    ST_DATA   = 3'd3,
    ST_STOP1  = 3'd4,
    ST_STOP2  = 3'd5
  } state_t;

  state_t     state, state_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] payload_first, payload_first_next;
  logic [7:0] payload_second, payload_second_next;
  logic [7:0] payload_third, payload_third_next;
  logic [7:0] b;
  logic [7:0] count_inc;

  assign rx_byte.ready = push_ready;
  assign push          = rx_byte.valid && push_ready;
  assign b             = rx_byte.data_byte;
  assign count_inc     = payload_count + 8'd1;

  always_comb begin
    state_next          = state;
    payload_count_next  = payload_count;
    frame_length_next   = frame_length;
    payload_first_next  = payload_first;
    payload_second_next = payload_second;
    payload_third_next  = payload_third;
    push_cmd            = '0;
    push_cmd.motor_addr = payload_first;
    push_cmd.direction  = payload_second;
    push_cmd.speed      = b;
    unique case (state)
      ST_HUNT: begin
        if (b == cfg.start_marker) begin
          payload_count_next = '0;
          state_next         = ST_START2;
        end
      end
      ST_START2: begin
        state_next = (b == cfg.start_marker) ? ST_LENGTH : ST_HUNT;
      end
      ST_LENGTH: begin
        frame_length_next  = b;
        payload_count_next = '0;
        if (b > cfg.max_length) begin
          state_next = ST_HUNT;
        end else if (b == 8'd0) begin
          state_next = ST_STOP1;
        end else begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        payload_count_next = count_inc;
        if (count_inc == frame_length) begin
          state_next = ST_STOP1;
        end
        if (count_inc == 8'd1) begin
          payload_first_next = b;
        end else if (count_inc == 8'd2) begin
          payload_second_next = b;
        end else if (count_inc == 8'd3) begin
          payload_third_next = b;
          push_cmd.motor     = 1'b1;
        end
      end
      ST_STOP1: begin
        state_next = (b == cfg.stop_marker) ? ST_STOP2 : ST_HUNT;
      end
      ST_STOP2: begin
        if (b == cfg.stop_marker) begin
          push_cmd.done = 1'b1;
          if (frame_length < LEN_MIN) begin
            push_cmd.status = STATUS_TOO_SHORT;
            push_cmd.addr   = NO_ADDRESS;
          end else begin
            push_cmd.addr = payload_first;
            if (frame_length == LEN_CHECKED) begin
              if (payload_first != ADDR_MOTOR_ONE && payload_first != ADDR_MOTOR_TWO) begin
                push_cmd.status = STATUS_ADDR_ERR;
              end else if (payload_third != MODE_THREE && payload_third != MODE_FOUR) begin
                push_cmd.status = STATUS_MODE_ERR;
              end else begin
                push_cmd.status = STATUS_OK;
              end
            end else if (frame_length != LEN_FOUR && frame_length != LEN_SIX) begin
              push_cmd.status = STATUS_LEN_ERR;
            end else begin
              push_cmd.status = STATUS_OK;
            end
          end
        end
        state_next = ST_HUNT;
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_HUNT;
      payload_count  <= '0;
      frame_length   <= '0;
      payload_first  <= '0;
      payload_second <= '0;
      payload_third  <= '0;
    end else if (push) begin
      state          <= state_next;
      payload_count  <= payload_count_next;
      frame_length   <= frame_length_next;
      payload_first  <= payload_first_next;
      payload_second <= payload_second_next;
      payload_third  <= payload_third_next;
    end
  end

  // a frame report and a motor command never come from the same byte
  assert property (@(posedge clk) disable iff (rst) push |-> !(push_cmd.done && push_cmd.motor))
    else $error("front: done and motor on one beat");
  // a motor command is only taken on the third payload byte
  assert property (@(posedge clk) disable iff (rst)
                   push && push_cmd.motor |=> payload_count == 8'd3)
    else $error("front: motor command off the third payload byte");
  // a report always follows a wait for the second stop marker
  assert property (@(posedge clk) disable iff (rst)
                   push && push_cmd.done |-> state == ST_STOP2)
    else $error("front: report outside second stop");

endmodule

`default_nettype wire

// File: hdl/fmcr_queue.sv
// fmcr_queue: short command queue between the parser and the motor back end
// depends on fmcr_pkg for the command type
`default_nettype none

module fmcr_queue #(
  parameter int DEPTH = fmcr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  fmcr_pkg::cmd_t  push_cmd,
  output logic            push_ready,
  input  wire             pop,
  output logic            pop_valid,
  output fmcr_pkg::cmd_t  pop_cmd
);
  import fmcr_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  cmd_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign push_ready = (count != Full);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= Full)
    else $error("queue: count beyond depth");
  assert property (@(posedge clk) disable iff (rst) pop |-> pop_valid)
    else $error("queue: pop while empty");
  assert property (@(posedge clk) disable iff (rst) push |-> push_ready)
    else $error("queue: push while full");

endmodule

`default_nettype wire

// File: hdl/fmcr_back.sv
// fmcr_back: applies motor commands to the four drive channels and holds the result beat
// depends on fmcr_pkg and fmcr_result_if; pops commands from the queue
`default_nettype none

module fmcr_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire [7:0]            speed_scale,
  input  wire                  pop_valid,
  input  fmcr_pkg::cmd_t       pop_cmd,
  output logic                 pop,
  fmcr_result_if.source        report
);
  import fmcr_pkg::*;

  logic        out_valid;
  logic        out_done;
  logic [2:0]  out_status;
  logic [7:0]  out_addr;
  logic        out_update;
  logic [3:0]  channel_on, channel_on_next;
  logic [15:0] compare_value [4];
  logic [15:0] product;
  logic        addr_hit;
  logic        dir_hit;
  logic [1:0]  ch;
  logic        apply;

  assign pop      = pop_valid && (!out_valid || report.ready);
  assign product  = 16'(pop_cmd.speed) * 16'(speed_scale);
  assign addr_hit = (pop_cmd.motor_addr == ADDR_MOTOR_ONE) ||
                    (pop_cmd.motor_addr == ADDR_MOTOR_TWO);
  assign apply    = pop && pop_cmd.motor && addr_hit;

  always_comb begin
    dir_hit = 1'b1;
    ch      = CH_ONE;
    if (pop_cmd.direction == DIR_ONE) begin
      ch = (pop_cmd.motor_addr == ADDR_MOTOR_ONE) ? CH_ONE : CH_FOUR;
    end else if (pop_cmd.direction == DIR_TWO) begin
      ch = (pop_cmd.motor_addr == ADDR_MOTOR_ONE) ? CH_TWO : CH_THREE;
    end else begin
      dir_hit = 1'b0;
    end
    channel_on_next = dir_hit ? (4'b0001 << ch) : 4'b0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      channel_on <= '0;
      for (int i = 0; i < 4; i++) begin
        compare_value[i] <= '0;
      end
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
      if (apply) begin
        channel_on <= channel_on_next;
        if (dir_hit) begin
          compare_value[ch] <= product;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_done   <= pop_cmd.done;
      out_status <= pop_cmd.status;
      out_addr   <= pop_cmd.addr;
      out_update <= pop_cmd.motor && addr_hit;
    end
  end

  assign report.valid          = out_valid;
  assign report.frame_done     = out_done;
  assign report.status         = out_status;
  assign report.reply_address  = out_addr;
  assign report.motor_update   = out_update;
  assign report.channel_enable = channel_on;
  assign report.compare_one    = compare_value[0];
  assign report.compare_two    = compare_value[1];
  assign report.compare_three  = compare_value[2];
  assign report.compare_four   = compare_value[3];

  assert property (@(posedge clk) disable iff (rst) $onehot0(channel_on))
    else $error("back: more than one channel running");
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !out_done |-> out_status == STATUS_OK && out_addr == 8'd0)
    else $error("back: status without a finished frame");
  assert property (@(posedge clk) disable iff (rst) !apply |=> $stable(channel_on))
    else $error("back: channels changed without a command");

endmodule

`default_nettype wire

// File: dv/fmcr_frame_checker.sv
// fmcr_frame_checker: predicts every report beat of the framed motor command receiver
// from the accepted byte and register beats, and compares each report beat field by field
// depends on fmcr_pkg; instantiated beside the block by the testbench top
module fmcr_frame_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        rx_valid,
  input  wire        rx_ready,
  input  wire [7:0]  rx_data,
  input  wire        cfg_valid,
  input  wire        cfg_ready,
  input  wire [7:0]  cfg_index,
  input  wire [7:0]  cfg_wdata,
  input  wire        rep_valid,
  input  wire        rep_ready,
  input  wire        rep_frame_done,
  input  wire [2:0]  rep_status,
  input  wire [7:0]  rep_reply_address,
  input  wire        rep_motor_update,
  input  wire [3:0]  rep_channel_enable,
  input  wire [15:0] rep_compare_one,
  input  wire [15:0] rep_compare_two,
  input  wire [15:0] rep_compare_three,
  input  wire [15:0] rep_compare_four,
  output int         outstanding,
  output int         mismatches
);
  import fmcr_pkg::*;

  typedef enum logic [2:0] {
    HUNT,
    SECOND_START,
    LENGTH_BYTE,
    PAYLOAD,
    FIRST_STOP,
    SECOND_STOP
  } parse_state_t;

  typedef struct packed {
    logic        frame_done;
    logic [2:0]  status;
    logic [7:0]  reply_address;
    logic        motor_update;
    logic [3:0]  channel_enable;
    logic [15:0] compare_one;
    logic [15:0] compare_two;
    logic [15:0] compare_three;
    logic [15:0] compare_four;
  } report_t;

  logic [7:0]   start_mk;
  logic [7:0]   stop_mk;
  logic [7:0]   max_len;
  logic [7:0]   scale;
  parse_state_t state;
  logic [7:0]   count;
  logic [7:0]   frame_len;
  logic [7:0]   first;
  logic [7:0]   second;
  logic [7:0]   third;
  logic [3:0]   running;
  logic [15:0]  compare_val [4];
  report_t      expected_reports [$];

  initial begin
    outstanding = 0;
    mismatches = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk) begin : track_frames
    report_t    seen;
    report_t    want;
    logic       has_channel;
    logic [1:0] ch;
    if (rst) begin
      start_mk = START_RESET;
      stop_mk = STOP_RESET;
      max_len = MAXLEN_RESET;
      scale = SCALE_RESET;
      state = HUNT;
      count = '0;
      frame_len = '0;
      first = '0;
      second = '0;
      third = '0;
      running = '0;
      foreach (compare_val[i]) compare_val[i] = '0;
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_MARKER: start_mk = cfg_wdata;
          REG_STOP_MARKER:  stop_mk = cfg_wdata;
          REG_MAX_LENGTH:   max_len = cfg_wdata;
          REG_SPEED_SCALE:  scale = cfg_wdata;
          default: ;
        endcase
      end

      // results are registered after their byte is accepted, so compare before predicting
      if (rep_valid && rep_ready) begin
        seen = '{frame_done: rep_frame_done, status: rep_status,
                 reply_address: rep_reply_address, motor_update: rep_motor_update,
                 channel_enable: rep_channel_enable, compare_one: rep_compare_one,
                 compare_two: rep_compare_two, compare_three: rep_compare_three,
                 compare_four: rep_compare_four};
        if (expected_reports.size() == 0) begin
          report_mismatch("report beat with nothing expected");
        end else begin
          want = expected_reports.pop_front();
          check_field("frame_done", seen.frame_done, want.frame_done);
          check_field("status", seen.status, want.status);
          check_field("reply_address", seen.reply_address, want.reply_address);
          check_field("motor_update", seen.motor_update, want.motor_update);
          check_field("channel_enable", seen.channel_enable, want.channel_enable);
          check_field("compare_one", seen.compare_one, want.compare_one);
          check_field("compare_two", seen.compare_two, want.compare_two);
          check_field("compare_three", seen.compare_three, want.compare_three);
          check_field("compare_four", seen.compare_four, want.compare_four);
        end
      end

      if (rx_valid && rx_ready) begin
        want = '0;
        case (state)
          HUNT: begin
            if (rx_data == start_mk) begin
              count = '0;
              state = SECOND_START;
            end
          end
          SECOND_START: state = (rx_data == start_mk) ? LENGTH_BYTE : HUNT;
          LENGTH_BYTE: begin
            frame_len = rx_data;
            count = '0;
            if (rx_data > max_len) state = HUNT;
            else if (rx_data == 8'd0) state = FIRST_STOP;
            else state = PAYLOAD;
          end
          PAYLOAD: begin
            count = count + 8'd1;
            if (count == frame_len) state = FIRST_STOP;
            if (count == 8'd1) begin
              first = rx_data;
            end else if (count == 8'd2) begin
              second = rx_data;
            end else if (count == 8'd3) begin
              third = rx_data;
              if (first == ADDR_MOTOR_ONE || first == ADDR_MOTOR_TWO) begin
                want.motor_update = 1'b1;
                running = '0;
                has_channel = 1'b1;
                ch = CH_ONE;
                if (second == DIR_ONE) ch = (first == ADDR_MOTOR_ONE) ? CH_ONE : CH_FOUR;
                else if (second == DIR_TWO) ch = (first == ADDR_MOTOR_ONE) ? CH_TWO : CH_THREE;
                else has_channel = 1'b0;
                if (has_channel) begin
                  running = 4'b0001 << ch;
                  compare_val[ch] = {8'd0, third} * {8'd0, scale};
                end
              end
            end
          end
          FIRST_STOP: state = (rx_data == stop_mk) ? SECOND_STOP : HUNT;
          SECOND_STOP: begin
            if (rx_data == stop_mk) begin
              want.frame_done = 1'b1;
              if (frame_len < LEN_MIN) begin
                want.status = STATUS_TOO_SHORT;
                want.reply_address = NO_ADDRESS;
              end else begin
                want.reply_address = first;
                want.status = STATUS_OK;
                if (frame_len == LEN_CHECKED) begin
                  if (first != ADDR_MOTOR_ONE && first != ADDR_MOTOR_TWO)
                    want.status = STATUS_ADDR_ERR;
                  else if (third != MODE_THREE && third != MODE_FOUR)
                    want.status = STATUS_MODE_ERR;
                end else if (frame_len != LEN_FOUR && frame_len != LEN_SIX) begin
                  want.status = STATUS_LEN_ERR;
                end
              end
            end
            state = HUNT;
          end
          default: state = HUNT;
        endcase
        want.channel_enable = running;
        want.compare_one = compare_val[CH_ONE];
        want.compare_two = compare_val[CH_TWO];
        want.compare_three = compare_val[CH_THREE];
        want.compare_four = compare_val[CH_FOUR];
        expected_reports.push_back(want);
      end
    end
    outstanding = expected_reports.size();
  end

endmodule

// File: dv/testbench.sv
// testbench: drives framed byte streams and register writes into the receiver core
// under random sender gaps and receiver stalls, and gives the verdict
// depends on fmcr_pkg, fmcr_if, framed_motor_command_receiver_core and fmcr_frame_checker
module testbench;
  import fmcr_pkg::*;

  localparam logic [7:0] DIRECTED [28] = '{
    // wrong second start
    START_RESET, 8'h00,
    // too long
    START_RESET, START_RESET, 8'hFC,
    // zero length
    START_RESET, START_RESET, 8'h00, STOP_RESET, STOP_RESET,
    // motor one forward at full speed, then a wrong second stop
    START_RESET, START_RESET, LEN_MIN, ADDR_MOTOR_ONE, DIR_ONE, 8'hFF, STOP_RESET, 8'h00,
    // checked length, motor two reverse, mode four
    START_RESET, START_RESET, LEN_CHECKED, ADDR_MOTOR_TWO, DIR_TWO, MODE_FOUR, 8'h00, 8'h00,
    STOP_RESET, STOP_RESET
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  int         gap_pct;
  int         stall_pct;
  int         hold_left;
  int         bytes_sent;
  int         outstanding;
  int         mismatches;
  logic [7:0] start_mk;
  logic [7:0] stop_mk;
  logic [7:0] max_len;

  fmcr_rx_if     rx_byte_if ();
  fmcr_result_if report_if ();
  fmcr_cfg_if    cfg_if ();

  always #4 clk = ~clk;

  framed_motor_command_receiver_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (rx_byte_if),
    .report  (report_if),
    .cfg     (cfg_if)
  );

  fmcr_frame_checker i_checker (
    .clk                (clk),
    .rst                (rst),
    .rx_valid           (rx_byte_if.valid),
    .rx_ready           (rx_byte_if.ready),
    .rx_data            (rx_byte_if.data_byte),
    .cfg_valid          (cfg_if.valid),
    .cfg_ready          (cfg_if.ready),
    .cfg_index          (cfg_if.index),
    .cfg_wdata          (cfg_if.wdata),
    .rep_valid          (report_if.valid),
    .rep_ready          (report_if.ready),
    .rep_frame_done     (report_if.frame_done),
    .rep_status         (report_if.status),
    .rep_reply_address  (report_if.reply_address),
    .rep_motor_update   (report_if.motor_update),
    .rep_channel_enable (report_if.channel_enable),
    .rep_compare_one    (report_if.compare_one),
    .rep_compare_two    (report_if.compare_two),
    .rep_compare_three  (report_if.compare_three),
    .rep_compare_four   (report_if.compare_four),
    .outstanding        (outstanding),
    .mismatches         (mismatches)
  );

  // report ready: long hold-off when requested, random stalls otherwise
  initial begin
    report_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        report_if.ready <= 1'b0;
        hold_left--;
      end else begin
        report_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      rx_byte_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_byte_if.valid <= 1'b1;
    rx_byte_if.data_byte <= b;
    do @(posedge clk); while (!rx_byte_if.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte(input logic [7:0] a, input logic [7:0] c);
    int r;
    r = $urandom_range(3);
    if (r == 0) return a;
    if (r == 1) return c;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_frame();
    int kind;
    int r;
    int len;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
    end else begin
      send_byte(start_mk);
      if (kind < 17) begin
        send_byte(start_mk ^ 8'($urandom_range(1, 255)));
      end else begin
        send_byte(start_mk);
        if (kind < 22 && max_len != 8'hFF) begin
          send_byte(8'($urandom_range(int'(max_len) + 1, 255)));
        end else begin
          r = $urandom_range(99);
          if (r < 85) len = $urandom_range(0, 7);
          else if (r < 97) len = $urandom_range(8, 20);
          else len = $urandom_range(21, 255);
          if (len > int'(max_len)) len = int'(max_len);
          send_byte(8'(len));
          for (int i = 0; i < len; i++) begin
            case (i)
              0: send_byte(pick_byte(ADDR_MOTOR_ONE, ADDR_MOTOR_TWO));
              1: send_byte(pick_byte(DIR_ONE, DIR_TWO));
              2: send_byte(pick_byte(MODE_THREE, MODE_FOUR));
              default: send_byte(8'($urandom_range(255)));
            endcase
          end
          if (kind < 30) begin
            if ($urandom_range(1) == 0) begin
              send_byte(stop_mk ^ 8'($urandom_range(1, 255)));
            end else begin
              send_byte(stop_mk);
              send_byte(stop_mk ^ 8'($urandom_range(1, 255)));
            end
          end else begin
            send_byte(stop_mk);
            send_byte(stop_mk);
          end
        end
      end
    end
  endtask

  task automatic drain_results();
    rx_byte_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_settings(input logic [7:0] start_v, input logic [7:0] stop_v,
                               input logic [7:0] max_v, input logic [7:0] scale_v);
    logic [7:0] idx [4];
    logic [7:0] val [4];
    idx = '{REG_START_MARKER, REG_STOP_MARKER, REG_MAX_LENGTH, REG_SPEED_SCALE};
    val = '{start_v, stop_v, max_v, scale_v};
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.wdata <= val[i];
      do @(posedge clk); while (!cfg_if.ready);
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
    start_mk = start_v;
    stop_mk = stop_v;
    max_len = max_v;
  endtask

  task automatic set_idling(input int gap, input int stall, input int hold);
    @(posedge clk);
    gap_pct = gap;
    stall_pct = stall;
    hold_left = hold;
    @(negedge clk);
  endtask

  initial begin
    rx_byte_if.valid = 1'b0;
    rx_byte_if.data_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.wdata = '0;
    start_mk = START_RESET;
    stop_mk = STOP_RESET;
    max_len = MAXLEN_RESET;
    gap_pct = 22;
    stall_pct = 73;
    hold_left = 0;
    bytes_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
    while (bytes_sent < 280) send_random_frame();

    drain_results();
    load_settings(8'h00, 8'hFF, 8'hFF, 8'hFF);
    set_idling(73, 22, 0);
    while (bytes_sent < 530) send_random_frame();

    drain_results();
    load_settings(8'hFF, 8'h00, 8'h00, 8'h00);
    set_idling(0, 0, 0);
    while (bytes_sent < 680) send_random_frame();

    // long report hold-off while bytes keep coming, so the block backs up
    drain_results();
    load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(6, 255)), 8'($urandom_range(255)));
    set_idling(0, 0, 80);
    while (bytes_sent < 880) send_random_frame();

    drain_results();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
hdl/fmcr_pkg.sv
hdl/fmcr_if.sv
hdl/fmcr_front.sv
hdl/fmcr_queue.sv
hdl/fmcr_back.sv
hdl/framed_motor_command_receiver_core.sv
dv/fmcr_frame_checker.sv
dv/testbench.sv
